// ----- src/key_to_midi_note_chord_tracker_assert.svh -----
// assertion macros for the key to midi note chord tracker
// used by the top level only, needs nothing else
`ifndef KEY_TO_MIDI_NOTE_CHORD_TRACKER_ASSERT_SVH
`define KEY_TO_MIDI_NOTE_CHORD_TRACKER_ASSERT_SVH

// a implies b in the same cycle
`define KMNCT_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("kmnct check failed: same cycle implication");

// a implies b in the next cycle
`define KMNCT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("kmnct check failed: next cycle implication");

`endif

// ----- src/kmnct_pkg.sv -----
// shared types, constants and note helpers of the key to midi note chord tracker
// no dependencies
package kmnct_pkg;

    localparam int KEY_COUNT_DEFAULT = 32;
    localparam int KEY_W   = 5;
    localparam int NOTE_W  = 7;
    localparam int CHAN_W  = 4;
    localparam int CNT_W   = 2;
    localparam int NOTES_W = 3 * NOTE_W;
    localparam int ENTRY_W = NOTES_W + CNT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [NOTE_W-1:0] VELOCITY    = 7'd100;
    localparam logic [NOTE_W-1:0] THIRD_STEP  = 7'd4;
    localparam logic [NOTE_W-1:0] FIFTH_STEP  = 7'd7;
    localparam logic [CNT_W-1:0]  TRIAD_SIZE  = 2'd3;
    localparam logic [CNT_W-1:0]  SINGLE_SIZE = 2'd1;

    localparam logic [CHAN_W-1:0] CHANNEL_RESET     = 4'd0;
    localparam logic [NOTE_W-1:0] SINGLE_BASE_RESET = 7'd60;
    localparam logic [NOTE_W-1:0] CHORD_BASE_RESET  = 7'd48;

    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_BASE_NOTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHORD_ROOT_BASE  = 2'd2;

    localparam logic EVENT_OFF = 1'b0;
    localparam logic EVENT_ON  = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] midi_channel;
        logic [NOTE_W-1:0] single_base_note;
        logic [NOTE_W-1:0] chord_root_base;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [NOTE_W-1:0] note;
        logic              last;
    } emit_t;

    // note sums wrap modulo 128 by truncation
    function automatic logic [NOTE_W-1:0] note_add(input logic [NOTE_W-1:0] base,
                                                   input logic [NOTE_W-1:0] offs);
        note_add = base + offs;
    endfunction

    function automatic logic [NOTE_W-1:0] pick_note(input logic [NOTES_W-1:0] notes,
                                                    input logic [CNT_W-1:0] slot);
        logic [NOTE_W-1:0] n;
        unique case (slot)
            2'd0:    n = notes[NOTE_W-1:0];
            2'd1:    n = notes[2*NOTE_W-1:NOTE_W];
            2'd2:    n = notes[3*NOTE_W-1:2*NOTE_W];
            default: n = notes[NOTE_W-1:0];
        endcase
        pick_note = n;
    endfunction

endpackage

// ----- src/kmnct_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module kmnct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/kmnct_engine.sv -----
// per key read-modify-write sequencer: reads the held entry, writes the new one back
// and steps through the note-off / note-on list; uses kmnct_pkg
module kmnct_engine #(
    parameter int KEY_COUNT = kmnct_pkg::KEY_COUNT_DEFAULT,
    parameter int AW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           key_valid,
    output logic                           key_stall,
    input  logic [kmnct_pkg::KEY_W-1:0]    key_index,
    input  logic [kmnct_pkg::NOTE_W-1:0]   relative_note,
    input  logic                           went_down,
    input  logic                           went_up,
    input  logic                           chord_mode,
    input  kmnct_pkg::cfg_t                cfg,
    input  logic                           out_free,
    output kmnct_pkg::emit_t               emit,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    input  logic [kmnct_pkg::ENTRY_W-1:0]  rd_data,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [kmnct_pkg::ENTRY_W-1:0]  wr_data
);
    import kmnct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [KEY_COUNT-1:0] valid_reg;
    logic [3:0] k_reg, k_next;

    // item payload
    logic [AW-1:0]     addr_reg;
    logic [NOTE_W-1:0] rel_reg;
    logic              range_reg, down_reg, up_reg, chord_reg;

    // emission plan
    logic [NOTES_W-1:0] old_notes_reg, new_notes_reg, fin_notes_reg;
    logic [CNT_W-1:0]   c0_reg;
    logic [2:0]         c01_reg;
    logic [3:0]         total_reg;

    logic              accept;
    logic [NOTES_W-1:0] old_notes, new_notes;
    logic [CNT_W-1:0]   old_cnt, new_cnt, c0, c1, c2;
    logic [2:0]         c01;
    logic [3:0]         total;
    logic              act_down, act_up;
    logic [NOTE_W-1:0] root, third, fifth, single;
    logic              emit_go;

    assign key_stall = (state_reg != ST_IDLE);
    assign accept    = key_valid && (state_reg == ST_IDLE);
    assign rd_en     = accept;
    assign rd_addr   = AW'(key_index);

    // new entry from the read data
    always_comb
    begin
        old_notes = rd_data[NOTES_W-1:0];
        old_cnt   = valid_reg[addr_reg] ? rd_data[ENTRY_W-1:NOTES_W] : '0;
        act_down  = down_reg && range_reg;
        act_up    = up_reg && range_reg;
        root      = note_add(cfg.chord_root_base, rel_reg);
        third     = note_add(root, THIRD_STEP);
        fifth     = note_add(root, FIFTH_STEP);
        single    = note_add(cfg.single_base_note, rel_reg);
        new_notes = chord_reg ? {fifth, third, root} : {{(2*NOTE_W){1'b0}}, single};
        new_cnt   = chord_reg ? TRIAD_SIZE : SINGLE_SIZE;
        c0        = act_down ? old_cnt : '0;
        c1        = act_down ? new_cnt : '0;
        c2        = act_up ? (act_down ? new_cnt : old_cnt) : '0;
        c01       = 3'(c0) + 3'(c1);
        total     = 4'(c01) + 4'(c2);
    end

    assign wr_en   = (state_reg == ST_LOAD) && (act_down || act_up);
    assign wr_addr = addr_reg;
    assign wr_data = {act_up ? CNT_W'(0) : new_cnt, new_notes};

    // current result from the plan
    assign emit_go = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        emit.valid = emit_go;
        emit.last  = (k_reg == (total_reg - 4'd1));
        priority if (k_reg < 4'(c0_reg))
        begin
            emit.kind = EVENT_OFF;
            emit.note = pick_note(old_notes_reg, k_reg[CNT_W-1:0]);
        end
        else if (k_reg < 4'(c01_reg))
        begin
            emit.kind = EVENT_ON;
            emit.note = pick_note(new_notes_reg, CNT_W'(k_reg - 4'(c0_reg)));
        end
        else
        begin
            emit.kind = EVENT_OFF;
            emit.note = pick_note(fin_notes_reg, CNT_W'(k_reg - 4'(c01_reg)));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                k_next     = '0;
                state_next = (total == 4'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    k_next = k_reg + 4'd1;
                    if (emit.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (wr_en)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= AW'(key_index);
            rel_reg   <= relative_note;
            range_reg <= (int'(key_index) < KEY_COUNT);
            down_reg  <= went_down;
            up_reg    <= went_up;
            chord_reg <= chord_mode;
        end
        if (state_reg == ST_LOAD)
        begin
            old_notes_reg <= old_notes;
            new_notes_reg <= new_notes;
            fin_notes_reg <= act_down ? new_notes : old_notes;
            c0_reg        <= c0;
            c01_reg       <= c01;
            total_reg     <= total;
        end
    end

endmodule

// ----- src/key_to_midi_note_chord_tracker.sv -----
// top level of the key to midi note chord tracker: config registers, held-note ram,
// sequencer and output register; uses kmnct_pkg, kmnct_ram, kmnct_engine and the assert header
//
// channel   direction  handshake            payload
// key       in         key_valid/key_stall  key_index relative_note went_down went_up chord_mode
// event     out        event_valid/stall    event_kind event_channel note_number velocity
//                                           last_event
// cfg       in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// an item gives n results (n up to 9) or none: the held-note ram is read first, then
// the plan is built and the entry written back, and the results then go one a cycle
// into the output register while that register is free
// key_stall is high from acceptance until the last result is in the output register
// event_stall holds the output register and pauses the sequencer
// reset clears the config to 0 / 60 / 48 and the per key valid bits, so no key holds notes
module key_to_midi_note_chord_tracker #(
    parameter int KEY_COUNT = kmnct_pkg::KEY_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // key requests
    input  logic                              key_valid,
    output logic                              key_stall,
    input  logic [kmnct_pkg::KEY_W-1:0]       key_index,
    input  logic signed [kmnct_pkg::NOTE_W-1:0] relative_note,
    input  logic                              went_down,
    input  logic                              went_up,
    input  logic                              chord_mode,
    // midi event requests
    output logic                              event_valid,
    input  logic                              event_stall,
    output logic                              event_kind,
    output logic [kmnct_pkg::CHAN_W-1:0]      event_channel,
    output logic [kmnct_pkg::NOTE_W-1:0]      note_number,
    output logic [kmnct_pkg::NOTE_W-1:0]      velocity,
    output logic                              last_event,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kmnct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kmnct_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kmnct_pkg::*;

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    cfg_t  cfg_reg;
    emit_t emit;

    logic               out_free;
    logic               event_valid_reg;
    logic               kind_reg, last_reg;
    logic [NOTE_W-1:0]  note_reg;
    logic [CHAN_W-1:0]  chan_reg;

    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [ENTRY_W-1:0] rd_data, wr_data;

    // config writes are always taken; indexes past the list fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midi_channel     <= CHANNEL_RESET;
            cfg_reg.single_base_note <= SINGLE_BASE_RESET;
            cfg_reg.chord_root_base  <= CHORD_BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIDI_CHANNEL:     cfg_reg.midi_channel     <= cfg_data[CHAN_W-1:0];
                REG_SINGLE_BASE_NOTE: cfg_reg.single_base_note <= cfg_data[NOTE_W-1:0];
                REG_CHORD_ROOT_BASE:  cfg_reg.chord_root_base  <= cfg_data[NOTE_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // held notes and count per key, one entry per key
    kmnct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT),
        .AW    (AW)
    ) u_held_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kmnct_engine #(
        .KEY_COUNT (KEY_COUNT),
        .AW        (AW)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_stall     (key_stall),
        .key_index     (key_index),
        .relative_note ($unsigned(relative_note)),
        .went_down     (went_down),
        .went_up       (went_up),
        .chord_mode    (chord_mode),
        .cfg           (cfg_reg),
        .out_free      (out_free),
        .emit          (emit),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !event_valid_reg || !event_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            event_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            kind_reg <= emit.kind;
            note_reg <= emit.note;
            last_reg <= emit.last;
            chan_reg <= cfg_reg.midi_channel;
        end
    end

    assign event_valid   = event_valid_reg;
    assign event_kind    = kind_reg;
    assign event_channel = chan_reg;
    assign note_number   = note_reg;
    assign velocity      = VELOCITY;
    assign last_event    = last_reg;

`include "key_to_midi_note_chord_tracker_assert.svh"

    // interlock: no second key request while the entry is being rewritten
    `KMNCT_ASSERT_NEXT(a_accept_locks, clk, rst_n, key_valid && !key_stall, key_stall)
    // the last result frees the key side in the next cycle
    `KMNCT_ASSERT_NEXT(a_last_frees, clk, rst_n, emit.valid && emit.last, !key_stall)
    // a result never overwrites one that is still waiting
    `KMNCT_ASSERT_SAME(a_no_overwrite, clk, rst_n, emit.valid,
                       !event_valid_reg || !event_stall)

endmodule
